// File: hdl/ilha_pkg.sv
// Shared types and constants for the implicit-list heap allocator.
// Used by ilha_ctrl, ilha_dpath and the top level; depends on nothing.
`default_nettype none
package ilha_pkg;

  localparam int ADDR_W = 36;   // byte address math, wide enough for damaged tags
  localparam int DATA_W = 32;
  localparam int OFF_W  = 16;
  localparam int REQ_W  = 16;
  localparam int ASZ_W  = 17;
  localparam int EXT_W  = 17;
  localparam int GSZ_W  = 18;
  localparam int STAT_W = 2;

  localparam logic [EXT_W-1:0]  EXTEND_RESET = 17'd4096;
  localparam logic [EXT_W-1:0]  INIT_CHUNK   = 17'd4096;
  localparam logic [ADDR_W-1:0] FIRST_BLOCK  = 36'd8;
  localparam logic [ADDR_W-1:0] WSIZE        = 36'd4;
  localparam logic [ADDR_W-1:0] DSIZE        = 36'd8;
  localparam logic [ADDR_W-1:0] BREAK_INIT   = 36'd16;
  localparam logic [DATA_W-1:0] MIN_BLOCK    = 32'd16;
  localparam logic [DATA_W-1:0] PROLOGUE_TAG = 32'h9;
  localparam logic [DATA_W-1:0] EPILOGUE_TAG = 32'h1;
  localparam logic [ADDR_W-1:0] PRO_HDR_ADDR = 36'd4;
  localparam logic [ADDR_W-1:0] PRO_FTR_ADDR = 36'd8;
  localparam logic [ADDR_W-1:0] EPI_ADDR     = 36'd12;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_OOM  = 2'd2;

  typedef enum logic [47:0] {
    S_CLR   = 48'd1 << 0,  S_INIT1 = 48'd1 << 1,  S_INIT2 = 48'd1 << 2,
    S_INIT3 = 48'd1 << 3,  S_IDLE  = 48'd1 << 4,  S_DISP  = 48'd1 << 5,
    S_ZERO  = 48'd1 << 6,  S_F0    = 48'd1 << 7,  S_F1    = 48'd1 << 8,
    S_F2    = 48'd1 << 9,  S_F3    = 48'd1 << 10, S_FF0   = 48'd1 << 11,
    S_FF1   = 48'd1 << 12, S_NF    = 48'd1 << 13, S_GROW0 = 48'd1 << 14,
    S_G1    = 48'd1 << 15, S_G2    = 48'd1 << 16, S_G3    = 48'd1 << 17,
    S_G4    = 48'd1 << 18, S_OOM   = 48'd1 << 19, S_MG0   = 48'd1 << 20,
    S_MG1   = 48'd1 << 21, S_MG2   = 48'd1 << 22, S_MG3   = 48'd1 << 23,
    S_MG4   = 48'd1 << 24, S_MG5   = 48'd1 << 25, S_MA1   = 48'd1 << 26,
    S_MA2   = 48'd1 << 27, S_MB1   = 48'd1 << 28, S_MB2   = 48'd1 << 29,
    S_MB3   = 48'd1 << 30, S_MB4   = 48'd1 << 31, S_MC0   = 48'd1 << 32,
    S_MC1   = 48'd1 << 33, S_MC2   = 48'd1 << 34, S_MC3   = 48'd1 << 35,
    S_MC4   = 48'd1 << 36, S_CV0   = 48'd1 << 37, S_CV1   = 48'd1 << 38,
    S_CS1   = 48'd1 << 39, S_CS2   = 48'd1 << 40, S_CS3   = 48'd1 << 41,
    S_CS4   = 48'd1 << 42, S_CS5   = 48'd1 << 43, S_CS6   = 48'd1 << 44,
    S_CN1   = 48'd1 << 45, S_CN2   = 48'd1 << 46, S_RESP  = 48'd1 << 47
  } state_t;

  typedef struct packed {
    state_t op;
    logic   take;
    logic   out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic req_zero;
    logic past;
    logic szero;
    logic fit;
    logic pa;
    logic na;
    logic split;
    logic oom;
    logic clr_last;
  } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/ilha_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ilha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: hdl/ilha_dpath.sv
// Allocator datapath: heap RAM, block pointers, size arithmetic, result regs.
// Depends on ilha_pkg and ilha_ram; driven one op per cycle by ilha_ctrl.
`default_nettype none
module ilha_dpath #(
  parameter int HEAP_BYTES = 65536
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ilha_pkg::ctl_cmd_t            cmd,
  output ilha_pkg::dp_status_t               st,
  input  wire logic                          command,
  input  wire logic [ilha_pkg::REQ_W-1:0]    request_size,
  input  wire logic [ilha_pkg::OFF_W-1:0]    block_offset,
  input  wire logic                          cfg_we,
  input  wire logic [ilha_pkg::EXT_W-1:0]    cfg_data,
  output logic      [ilha_pkg::OFF_W-1:0]    payload_offset,
  output logic      [ilha_pkg::STAT_W-1:0]   status
);

  localparam int NWORDS = HEAP_BYTES / 4;
  localparam int IW     = $clog2(NWORDS);
  localparam int AW     = ilha_pkg::ADDR_W;
  localparam int DW     = ilha_pkg::DATA_W;

  localparam logic [AW-1:0]   HEAP_LIM = AW'(HEAP_BYTES);
  localparam logic [AW-3:0]   NW_LIM   = (AW-2)'(NWORDS);
  localparam logic [IW-1:0]   CLR_LAST = IW'(NWORDS - 1);

  logic [AW-1:0] bp, pp, nn, brk;
  logic [DW-1:0] s, c, sz_a, sz_p;
  logic [ilha_pkg::ASZ_W-1:0] asize;
  logic [ilha_pkg::EXT_W-1:0] ext, extend;
  logic pa_r, is_free_r, req_zero_r, oor_q;
  logic [IW-1:0] clr_idx;
  logic [ilha_pkg::OFF_W-1:0]  res_off;
  logic [ilha_pkg::STAT_W-1:0] res_st;

  logic [DW-1:0] rdata, d, szd, sum_as, sum_ap, sum_apd, asz32, c_rem;
  logic [AW-1:0] szx, acc_addr, brk_g;
  logic [15:0] wsum;
  logic [ilha_pkg::GSZ_W-1:0] gsz;
  logic [ilha_pkg::ASZ_W-1:0] asize_in;
  logic [ilha_pkg::REQ_W:0] req_pad;
  logic wr_req, in_range, oom, fit, split, ram_we;
  logic [DW-1:0] wr_data, ram_wdata;
  logic [IW-1:0] ram_addr;

  assign d       = oor_q ? '0 : rdata;
  assign szd     = {d[DW-1:3], 3'b000};
  assign szx     = AW'(szd);
  assign sum_as  = sz_a + szd;
  assign sum_ap  = sz_a + sz_p;
  assign sum_apd = sum_ap + szd;
  assign asz32   = DW'(asize);
  assign c_rem   = c - asz32;
  assign wsum    = 16'(ext[ilha_pkg::EXT_W-1:2]) + 16'(ext[2]);
  assign gsz     = {wsum, 2'b00};
  assign brk_g   = brk + AW'(gsz);
  assign oom     = brk_g > HEAP_LIM;
  assign fit     = !d[0] && (asz32 <= szd);
  assign split   = (szd - asz32) >= ilha_pkg::MIN_BLOCK;
  // 16 for tiny requests, else round payload plus tags up to a multiple of 8
  assign req_pad  = {1'b0, request_size} + 17'd15;
  assign asize_in = (request_size <= 16'd8) ? 17'd16 : {req_pad[16:3], 3'b000};

  always_comb begin
    acc_addr = bp - ilha_pkg::WSIZE;
    wr_req   = 1'b0;
    wr_data  = s;
    unique case (cmd.op)
      ilha_pkg::S_INIT1: begin
        acc_addr = ilha_pkg::PRO_HDR_ADDR; wr_req = 1'b1; wr_data = ilha_pkg::PROLOGUE_TAG;
      end
      ilha_pkg::S_INIT2: begin
        acc_addr = ilha_pkg::PRO_FTR_ADDR; wr_req = 1'b1; wr_data = ilha_pkg::PROLOGUE_TAG;
      end
      ilha_pkg::S_INIT3: begin
        acc_addr = ilha_pkg::EPI_ADDR; wr_req = 1'b1; wr_data = ilha_pkg::EPILOGUE_TAG;
      end
      ilha_pkg::S_F1: begin
        wr_req = 1'b1; wr_data = szd;
      end
      ilha_pkg::S_F3, ilha_pkg::S_G2, ilha_pkg::S_MA2: begin
        acc_addr = bp + szx - ilha_pkg::DSIZE; wr_req = 1'b1;
      end
      ilha_pkg::S_GROW0: begin
        acc_addr = brk - ilha_pkg::WSIZE; wr_req = !oom; wr_data = DW'(gsz);
      end
      ilha_pkg::S_G4: begin
        acc_addr = bp + szx - ilha_pkg::WSIZE; wr_req = 1'b1;
        wr_data  = ilha_pkg::EPILOGUE_TAG;
      end
      ilha_pkg::S_MG0, ilha_pkg::S_MB1, ilha_pkg::S_MB3, ilha_pkg::S_MC0: begin
        acc_addr = bp - ilha_pkg::DSIZE;
      end
      ilha_pkg::S_MG1: acc_addr = bp - szx - ilha_pkg::WSIZE;
      ilha_pkg::S_MG2: acc_addr = pp + szx - ilha_pkg::DSIZE;
      ilha_pkg::S_MG4, ilha_pkg::S_MC3: acc_addr = bp + szx - ilha_pkg::WSIZE;
      ilha_pkg::S_MG5: begin
        if (pa_r && !d[0]) begin
          wr_req = 1'b1; wr_data = sum_as;
        end else if (!pa_r && d[0]) begin
          acc_addr = bp + AW'(sz_a) - ilha_pkg::DSIZE; wr_req = 1'b1; wr_data = sum_ap;
        end else if (!pa_r) begin
          acc_addr = nn + szx - ilha_pkg::DSIZE;
        end
      end
      ilha_pkg::S_MB2, ilha_pkg::S_MC1: begin
        acc_addr = bp - szx - ilha_pkg::WSIZE; wr_req = 1'b1;
      end
      ilha_pkg::S_MC4: begin
        acc_addr = nn + szx - ilha_pkg::DSIZE; wr_req = 1'b1;
      end
      ilha_pkg::S_CV1: begin
        wr_req  = 1'b1;
        wr_data = split ? (asz32 | 32'h1) : (szd | 32'h1);
      end
      ilha_pkg::S_CS2: begin
        acc_addr = bp + szx - ilha_pkg::DSIZE; wr_req = 1'b1; wr_data = asz32 | 32'h1;
      end
      ilha_pkg::S_CS4: begin
        acc_addr = bp + szx - ilha_pkg::WSIZE; wr_req = 1'b1; wr_data = c_rem;
      end
      ilha_pkg::S_CS5: acc_addr = nn - ilha_pkg::WSIZE;
      ilha_pkg::S_CS6: begin
        acc_addr = nn + szx - ilha_pkg::DSIZE; wr_req = 1'b1; wr_data = c_rem;
      end
      ilha_pkg::S_CN2: begin
        acc_addr = bp + szx - ilha_pkg::DSIZE; wr_req = 1'b1; wr_data = c | 32'h1;
      end
      default: ;
    endcase
  end

  // addresses outside the heap read as zero and drop writes
  assign in_range  = acc_addr[AW-1:2] < NW_LIM;
  assign ram_addr  = (cmd.op == ilha_pkg::S_CLR) ? clr_idx : acc_addr[IW+1:2];
  assign ram_we    = (cmd.op == ilha_pkg::S_CLR) || (wr_req && in_range);
  assign ram_wdata = (cmd.op == ilha_pkg::S_CLR) ? '0 : wr_data;

  ilha_ram #(.WIDTH(DW), .DEPTH(NWORDS)) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      extend  <= ilha_pkg::EXTEND_RESET;
    end else begin
      if (cmd.op == ilha_pkg::S_CLR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cfg_we) begin
        extend <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    oor_q <= !in_range;
    if (cmd.take) begin
      bp         <= command ? AW'(block_offset) : ilha_pkg::FIRST_BLOCK;
      is_free_r  <= command;
      req_zero_r <= (request_size == '0);
      asize      <= asize_in;
    end
    if (cmd.out_load) begin
      payload_offset <= res_off;
      status         <= res_st;
    end
    unique case (cmd.op)
      ilha_pkg::S_INIT3: begin
        brk <= ilha_pkg::BREAK_INIT;
        ext <= ilha_pkg::INIT_CHUNK;
      end
      ilha_pkg::S_ZERO: begin
        res_off <= '0; res_st <= ilha_pkg::ST_ZERO;
      end
      ilha_pkg::S_F0: begin
        res_off <= bp[ilha_pkg::OFF_W-1:0]; res_st <= ilha_pkg::ST_OK;
      end
      ilha_pkg::S_F1: s <= szd;
      ilha_pkg::S_FF1: begin
        if (!fit) begin
          bp <= bp + szx;
        end
      end
      ilha_pkg::S_NF: ext <= (asize > extend) ? asize : extend;
      ilha_pkg::S_GROW0: begin
        if (!oom) begin
          bp  <= brk;
          brk <= brk_g;
          s   <= DW'(gsz);
        end
      end
      ilha_pkg::S_OOM: begin
        res_off <= '0; res_st <= ilha_pkg::ST_OOM;
      end
      ilha_pkg::S_MG1: pp <= bp - szx;
      ilha_pkg::S_MG2: sz_p <= szd;
      ilha_pkg::S_MG3: pa_r <= d[0];
      ilha_pkg::S_MG4: begin
        sz_a <= szd;
        nn   <= bp + szx;
      end
      ilha_pkg::S_MG5: begin
        if (pa_r && !d[0]) begin
          s <= sum_as;
        end else if (!pa_r && d[0]) begin
          s <= sum_ap;
        end
      end
      ilha_pkg::S_MB4: bp <= bp - szx;
      ilha_pkg::S_MC0: s <= sum_apd;
      ilha_pkg::S_MC3, ilha_pkg::S_CS4: nn <= bp + szx;
      ilha_pkg::S_CV1: begin
        c       <= szd;
        res_off <= bp[ilha_pkg::OFF_W-1:0];
        res_st  <= ilha_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.is_free  = is_free_r;
    st.req_zero = req_zero_r;
    st.past     = bp > brk;
    st.szero    = (szd == '0);
    st.fit      = fit;
    st.pa       = pa_r;
    st.na       = d[0];
    st.split    = split;
    st.oom      = oom;
    st.clr_last = (clr_idx == CLR_LAST);
  end

endmodule
`default_nettype wire

// File: hdl/ilha_ctrl.sv
// Allocator sequencer: one-hot state machine issuing one datapath op per cycle.
// Depends on ilha_pkg.
`default_nettype none
module ilha_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire ilha_pkg::dp_status_t st,
  output ilha_pkg::ctl_cmd_t        cmd
);

  ilha_pkg::state_t state, state_next, ret_st;
  logic call_grow, call_grow_next, init, out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ilha_pkg::S_IDLE);

  // where a merge returns: free -> respond, grow -> carve (or idle after reset build)
  assign ret_st = call_grow ? (init ? ilha_pkg::S_IDLE : ilha_pkg::S_CV0) : ilha_pkg::S_RESP;

  always_comb begin
    cmd.op       = state;
    cmd.take     = (state == ilha_pkg::S_IDLE) && in_valid;
    cmd.out_load = (state == ilha_pkg::S_RESP) && out_free;
  end

  always_comb begin
    state_next     = state;
    call_grow_next = call_grow;
    unique case (state)
      ilha_pkg::S_CLR:   if (st.clr_last) state_next = ilha_pkg::S_INIT1;
      ilha_pkg::S_INIT1: state_next = ilha_pkg::S_INIT2;
      ilha_pkg::S_INIT2: state_next = ilha_pkg::S_INIT3;
      ilha_pkg::S_INIT3: state_next = ilha_pkg::S_GROW0;
      ilha_pkg::S_IDLE:  if (in_valid) state_next = ilha_pkg::S_DISP;
      ilha_pkg::S_DISP: begin
        if (st.is_free) state_next = ilha_pkg::S_F0;
        else if (st.req_zero) state_next = ilha_pkg::S_ZERO;
        else state_next = ilha_pkg::S_FF0;
      end
      ilha_pkg::S_ZERO:  state_next = ilha_pkg::S_RESP;
      ilha_pkg::S_F0:    state_next = ilha_pkg::S_F1;
      ilha_pkg::S_F1:    state_next = ilha_pkg::S_F2;
      ilha_pkg::S_F2:    state_next = ilha_pkg::S_F3;
      ilha_pkg::S_F3: begin
        state_next = ilha_pkg::S_MG0; call_grow_next = 1'b0;
      end
      ilha_pkg::S_FF0:   state_next = st.past ? ilha_pkg::S_NF : ilha_pkg::S_FF1;
      ilha_pkg::S_FF1: begin
        if (st.szero) state_next = ilha_pkg::S_NF;
        else if (st.fit) state_next = ilha_pkg::S_CV0;
        else state_next = ilha_pkg::S_FF0;
      end
      ilha_pkg::S_NF:    state_next = ilha_pkg::S_GROW0;
      ilha_pkg::S_GROW0: begin
        if (st.oom) state_next = init ? ilha_pkg::S_IDLE : ilha_pkg::S_OOM;
        else state_next = ilha_pkg::S_G1;
      end
      ilha_pkg::S_G1:    state_next = ilha_pkg::S_G2;
      ilha_pkg::S_G2:    state_next = ilha_pkg::S_G3;
      ilha_pkg::S_G3:    state_next = ilha_pkg::S_G4;
      ilha_pkg::S_G4: begin
        state_next = ilha_pkg::S_MG0; call_grow_next = 1'b1;
      end
      ilha_pkg::S_OOM:   state_next = ilha_pkg::S_RESP;
      ilha_pkg::S_MG0:   state_next = ilha_pkg::S_MG1;
      ilha_pkg::S_MG1:   state_next = ilha_pkg::S_MG2;
      ilha_pkg::S_MG2:   state_next = ilha_pkg::S_MG3;
      ilha_pkg::S_MG3:   state_next = ilha_pkg::S_MG4;
      ilha_pkg::S_MG4:   state_next = ilha_pkg::S_MG5;
      ilha_pkg::S_MG5: begin
        if (st.pa && st.na) state_next = ret_st;
        else if (st.pa) state_next = ilha_pkg::S_MA1;
        else if (st.na) state_next = ilha_pkg::S_MB1;
        else state_next = ilha_pkg::S_MC0;
      end
      ilha_pkg::S_MA1:   state_next = ilha_pkg::S_MA2;
      ilha_pkg::S_MA2:   state_next = ret_st;
      ilha_pkg::S_MB1:   state_next = ilha_pkg::S_MB2;
      ilha_pkg::S_MB2:   state_next = ilha_pkg::S_MB3;
      ilha_pkg::S_MB3:   state_next = ilha_pkg::S_MB4;
      ilha_pkg::S_MB4:   state_next = ret_st;
      ilha_pkg::S_MC0:   state_next = ilha_pkg::S_MC1;
      ilha_pkg::S_MC1:   state_next = ilha_pkg::S_MC2;
      ilha_pkg::S_MC2:   state_next = ilha_pkg::S_MC3;
      ilha_pkg::S_MC3:   state_next = ilha_pkg::S_MC4;
      ilha_pkg::S_MC4:   state_next = ilha_pkg::S_MB3;
      ilha_pkg::S_CV0:   state_next = ilha_pkg::S_CV1;
      ilha_pkg::S_CV1:   state_next = st.split ? ilha_pkg::S_CS1 : ilha_pkg::S_CN1;
      ilha_pkg::S_CS1:   state_next = ilha_pkg::S_CS2;
      ilha_pkg::S_CS2:   state_next = ilha_pkg::S_CS3;
      ilha_pkg::S_CS3:   state_next = ilha_pkg::S_CS4;
      ilha_pkg::S_CS4:   state_next = ilha_pkg::S_CS5;
      ilha_pkg::S_CS5:   state_next = ilha_pkg::S_CS6;
      ilha_pkg::S_CS6:   state_next = ilha_pkg::S_RESP;
      ilha_pkg::S_CN1:   state_next = ilha_pkg::S_CN2;
      ilha_pkg::S_CN2:   state_next = ilha_pkg::S_RESP;
      ilha_pkg::S_RESP:  if (out_free) state_next = ilha_pkg::S_IDLE;
      default:           state_next = ilha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ilha_pkg::S_CLR;
      call_grow <= 1'b0;
      init      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      call_grow <= call_grow_next;
      if (state == ilha_pkg::S_IDLE) begin
        init <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/implicit_list_heap_allocator_unit.sv
// Boundary-tag heap allocator, first fit, over an on-chip word RAM.
// Input channel (in_valid/in_stall): command 0 allocates request_size bytes,
// command 1 frees the payload at block_offset. Output channel
// (out_valid/out_stall): one word per request, payload_offset and status
// (0 ok, 1 zero-size request, 2 out of memory).
// cfg_we/cfg_data set the minimum heap growth in bytes (reset 4096).
// Requests are served one at a time. A zero-size request is answered
// without touching the heap; a free rewrites the block's tags and then
// merges it with any free neighbor. An allocate scans the block headers
// first fit through the single heap RAM port, grows the heap (tag writes
// plus merge) when no block fits, then carves the block, splitting off any remainder of 16 bytes or more.
// The next request is taken while a result still waits on out_stall; it
// then holds its answer until the output register frees.
// Reset: the heap RAM is swept to zero, one word per cycle over all
// HEAP_BYTES/4 words, then prologue, a 4096-byte free chunk and the epilogue are
// written; in_stall stays high through all of it.
// Depends on ilha_pkg, ilha_ctrl, ilha_dpath, ilha_ram.
`default_nettype none
module implicit_list_heap_allocator_unit #(
  parameter int HEAP_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [15:0] request_size,
  input  wire logic [15:0] block_offset,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] payload_offset,
  output logic      [1:0]  status,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_data
);

  ilha_pkg::ctl_cmd_t   cmd;
  ilha_pkg::dp_status_t st;

  ilha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  ilha_dpath #(.HEAP_BYTES(HEAP_BYTES)) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .command        (command),
    .request_size   (request_size),
    .block_offset   (block_offset),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .payload_offset (payload_offset),
    .status         (status)
  );

  // reset always lands in the clearing sweep
  a_rst_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ilha_pkg::ST_OK || status == ilha_pkg::ST_ZERO ||
                   status == ilha_pkg::ST_OOM))
    else $error("bad status code");

  a_null_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ilha_pkg::ST_OK) |-> (payload_offset == '0))
    else $error("failed request returned nonzero offset");

endmodule
`default_nettype wire

// File: tb/sv/tb_implicit_list_heap_allocator_unit.sv
// Self-checking bench for implicit_list_heap_allocator_unit: random alloc/free traffic
// against a boundary-tag first-fit heap predictor held in a small scoreboard class.
// Depends on ilha_pkg and the allocator RTL.
`timescale 1ns / 100ps
`default_nettype none

typedef struct {
  logic [15:0] offset;
  logic [1:0]  stat;
} reply_t;

class heap_scoreboard;
  localparam int HEAP_SZ = 65536;
  localparam int NUM_WORDS = HEAP_SZ / 4;

  logic [31:0]      heap_mem [NUM_WORDS];
  longint unsigned  brk;
  logic [16:0]      grow_min;
  reply_t           replies [$];
  int               mismatches;

  function new();
    foreach (heap_mem[i]) heap_mem[i] = '0;
    grow_min = ilha_pkg::EXTEND_RESET;
    heap_mem[1] = ilha_pkg::PROLOGUE_TAG;
    heap_mem[2] = ilha_pkg::PROLOGUE_TAG;
    heap_mem[3] = ilha_pkg::EPILOGUE_TAG;
    brk = 16;
    void'(grow_heap(4096));
    mismatches = 0;
  endfunction

  function logic [31:0] word_at(longint unsigned a);
    longint unsigned i;
    i = a >> 2;
    return (i < NUM_WORDS) ? heap_mem[i] : 32'd0;
  endfunction

  function void put_word(longint unsigned a, logic [31:0] v);
    longint unsigned i;
    i = a >> 2;
    if (i < NUM_WORDS) heap_mem[i] = v;
  endfunction

  function logic [31:0] tag_size(longint unsigned a);
    return word_at(a) & ~32'h7;
  endfunction

  function bit tag_used(longint unsigned a);
    logic [31:0] w;
    w = word_at(a);
    return w[0];
  endfunction

  function longint unsigned next_bp(longint unsigned bp);
    return bp + tag_size(bp - 4);
  endfunction

  function longint unsigned prev_bp(longint unsigned bp);
    return bp - tag_size(bp - 8);
  endfunction

  function longint unsigned foot(longint unsigned bp);
    return bp + tag_size(bp - 4) - 8;
  endfunction

  function longint unsigned merge_free(longint unsigned bp);
    bit          pa, na;
    logic [31:0] s;
    pa = tag_used(foot(prev_bp(bp)));
    na = tag_used(next_bp(bp) - 4);
    s  = tag_size(bp - 4);
    if (pa && na) return bp;
    if (pa) begin
      s += tag_size(next_bp(bp) - 4);
      put_word(bp - 4, s);
      put_word(foot(bp), s);
    end else if (na) begin
      s += tag_size(prev_bp(bp) - 4);
      put_word(foot(bp), s);
      put_word(prev_bp(bp) - 4, s);
      bp = prev_bp(bp);
    end else begin
      s += tag_size(prev_bp(bp) - 4) + tag_size(foot(next_bp(bp)));
      put_word(prev_bp(bp) - 4, s);
      put_word(foot(next_bp(bp)), s);
      bp = prev_bp(bp);
    end
    return bp;
  endfunction

  function longint unsigned grow_heap(logic [31:0] nbytes);
    logic [31:0]     w, s;
    longint unsigned bp;
    w  = nbytes / 4;
    s  = (w[0] ? w + 1 : w) * 4;
    bp = brk;
    if (bp + s > HEAP_SZ) return 0;
    brk = bp + s;
    put_word(bp - 4, s);
    put_word(foot(bp), s);
    put_word(next_bp(bp) - 4, 32'h1);
    return merge_free(bp);
  endfunction

  function longint unsigned scan_first_fit(logic [31:0] asize);
    longint unsigned bp;
    logic [31:0]     s;
    bp = 8;
    while (bp <= brk) begin
      s = tag_size(bp - 4);
      if (s == 0) break;
      if (!tag_used(bp - 4) && asize <= s) return bp;
      bp += s;
    end
    return 0;
  endfunction

  function void split_block(longint unsigned bp, logic [31:0] asize);
    logic [31:0] c;
    c = tag_size(bp - 4);
    if (c - asize >= 16) begin
      put_word(bp - 4, asize | 1);
      put_word(foot(bp), asize | 1);
      bp = next_bp(bp);
      put_word(bp - 4, c - asize);
      put_word(foot(bp), c - asize);
    end else begin
      put_word(bp - 4, c | 1);
      put_word(foot(bp), c | 1);
    end
  endfunction

  // Predict the reply for one accepted request word and queue it.
  function reply_t note_request(logic cmd, logic [15:0] req, logic [15:0] off);
    reply_t          r;
    logic [31:0]     asize, s, ext;
    longint unsigned bp;
    r.offset = '0;
    r.stat   = ilha_pkg::ST_OK;
    if (cmd) begin
      bp = off;
      s  = tag_size(bp - 4);
      put_word(bp - 4, s);
      put_word(foot(bp), s);
      void'(merge_free(bp));
      r.offset = off;
    end else if (req == 0) begin
      r.stat = ilha_pkg::ST_ZERO;
    end else begin
      asize = (req <= 8) ? 32'd16 : 8 * ((32'(req) + 15) / 8);
      bp = scan_first_fit(asize);
      if (bp == 0) begin
        ext = (asize > grow_min) ? asize : 32'(grow_min);
        bp  = grow_heap(ext);
      end
      if (bp == 0) begin
        r.stat = ilha_pkg::ST_OOM;
      end else begin
        split_block(bp, asize);
        r.offset = bp[15:0];
      end
    end
    replies.push_back(r);
    return r;
  endfunction

  function void check_reply(logic [15:0] off, logic [1:0] st);
    reply_t e;
    if (replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected reply word: offset %0d status %0d", off, st);
      return;
    end
    e = replies.pop_front();
    if (e.offset !== off || e.stat !== st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("reply mismatch: exp offset %0d status %0d, got offset %0d status %0d",
                 e.offset, e.stat, off, st);
    end
  endfunction

  function int pending();
    return replies.size();
  endfunction
endclass

module tb_implicit_list_heap_allocator_unit;

  localparam int IDLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1120;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [15:0] request_size = '0;
  logic [15:0] block_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] payload_offset;
  logic [1:0]  status;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_data = '0;

  heap_scoreboard sb = new();
  logic [15:0]    live_blocks [$];
  int             idle_cycles = 0;
  int             stall_mode = 0;
  int             stall_cycle = 0;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  implicit_list_heap_allocator_unit u_top (
    .clk, .rst, .in_valid, .in_stall, .command, .request_size, .block_offset,
    .out_valid, .out_stall, .payload_offset, .status, .cfg_we, .cfg_data
  );

  always #5 clk = ~clk;

  // Reply monitor, stall pattern and watchdog.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_reply(payload_offset, status);
    if ((out_valid && !out_stall) || (in_valid && !in_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ((stall_cycle / 8) % 2 == 1);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Present one word and hold it until accepted; the call starts and ends at a rising edge.
  task automatic send_word(input logic cmd, input logic [15:0] req, input logic [15:0] off,
                           output reply_t r);
    in_valid     <= 1'b1;
    command      <= cmd;
    request_size <= req;
    block_offset <= off;
    do @(posedge clk); while (in_stall);
    r = sb.note_request(cmd, req, off);
    if (!cmd && r.stat == ilha_pkg::ST_OK) live_blocks.push_back(r.offset);
  endtask

  task automatic do_alloc(input logic [15:0] req);
    reply_t r;
    send_word(CMD_ALLOC, req, 16'($urandom), r);
  endtask

  task automatic do_free(input int idx);
    reply_t r;
    logic [15:0] off;
    off = live_blocks[idx];
    live_blocks.delete(idx);
    send_word(CMD_FREE, 16'($urandom), off, r);
  endtask

  task automatic pause(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_growth(input logic [16:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.grow_min = v;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 16'd0;
    if (r < 60) return 16'($urandom_range(1, 64));
    if (r < 90) return 16'($urandom_range(65, 1024));
    if (r < 98) return 16'($urandom_range(1025, 8192));
    return 16'($urandom);
  endfunction

  task automatic random_phase(input int n);
    int burst;
    burst = $urandom_range(1, 20);
    for (int k = 0; k < n; k++) begin
      if (live_blocks.size() > 0 && $urandom_range(0, 99) < 45)
        do_free($urandom_range(0, live_blocks.size() - 1));
      else
        do_alloc(pick_size());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    reply_t r;
    logic [15:0] p [6];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    // directed: zero size, smallest sizes, rounding edge, all four merge cases, growth, OOM
    send_word(CMD_ALLOC, 16'd0, 16'hFFFF, r);
    foreach (p[i]) begin
      send_word(CMD_ALLOC, (i == 0) ? 16'd1 : (i == 1) ? 16'd8 : (i == 2) ? 16'd9 :
                (i == 3) ? 16'd24 : (i == 4) ? 16'd100 : 16'd40, 16'd0, r);
      p[i] = r.offset;
    end
    live_blocks.delete();
    send_word(CMD_FREE, 16'hFFFF, p[1], r);   // both neighbors in use
    send_word(CMD_FREE, 16'd0, p[3], r);      // both neighbors in use
    send_word(CMD_FREE, 16'd0, p[2], r);      // both neighbors free
    send_word(CMD_FREE, 16'd0, p[0], r);      // next free only
    send_word(CMD_FREE, 16'd0, p[5], r);      // prev in use, next free tail
    send_word(CMD_ALLOC, 16'd5000, 16'd0, r); // grows and merges with free tail
    send_word(CMD_ALLOC, 16'd65535, 16'd0, r);// out of memory
    send_word(CMD_ALLOC, 16'd120, 16'd0, r);  // first fit lands in the split-off remainder, which splits again
    send_word(CMD_FREE, 16'd0, p[4], r);      // prev free, next in use
    live_blocks.delete();
    drain();  // sender holds off until every reply is back

    set_growth(17'd16);
    random_phase(RANDOM_ITEMS / 4);
    drain();
    set_growth(17'd65536);
    random_phase(RANDOM_ITEMS / 4);
    drain();
    set_growth(17'($urandom_range(16, 65536)));
    random_phase(RANDOM_ITEMS / 4);
    drain();
    set_growth(17'd4096);
    random_phase(RANDOM_ITEMS / 4 - 8);
    // frees at arbitrary offsets; their replies still go through the scoreboard
    repeat (4) send_word(CMD_FREE, 16'($urandom), 16'($urandom), r);
    send_word(CMD_FREE, 16'd0, 16'd0, r);
    send_word(CMD_FREE, 16'hFFFF, 16'hFFFF, r);
    do_alloc(16'd64);
    do_alloc(16'd1);
    drain();

    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
hdl/ilha_pkg.sv
hdl/ilha_ram.sv
hdl/ilha_dpath.sv
hdl/ilha_ctrl.sv
hdl/implicit_list_heap_allocator_unit.sv
tb/sv/tb_implicit_list_heap_allocator_unit.sv
